### design/eased_timed_pose_blend_defines.svh
// ----------------------------------------------------------------------------
// eased timed pose blend assertion macros
// shared assertion wrappers, removed as a whole when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef EASED_TIMED_POSE_BLEND_DEFINES_SVH
`define EASED_TIMED_POSE_BLEND_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ETPB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("etpb assertion failed");
// condition must never be seen outside reset
`define ETPB_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("etpb forbidden condition seen");
`else
`define ETPB_ASSERT(name, prop)
`define ETPB_ASSERT_NEVER(name, cond)
`endif

`endif

### design/etpb_pkg.sv
// ----------------------------------------------------------------------------
// etpb_pkg
// types, codes and defaults shared by the eased timed pose blend modules
// ----------------------------------------------------------------------------
package etpb_pkg;

  // default configuration of the pose store and fixed-point format
  localparam int unsigned DEF_POSE_COMPONENTS = 9;
  localparam int unsigned DEF_FRACTION_BITS   = 16;

  // configuration register indexes
  localparam logic CFG_DURATION = 1'b0;
  localparam logic CFG_CURVE    = 1'b1;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  // easing curve codes
  typedef enum logic [1:0] {
    CURVE_LINEAR   = 2'd0,
    CURVE_EASE_IN  = 2'd1,
    CURVE_EASE_OUT = 2'd2,
    CURVE_SMOOTH   = 2'd3
  } curve_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EASE1,
    ST_EASE2,
    ST_CALC,
    ST_EMIT
  } state_e;

  // what a tick emits per component
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_LERP,
    MODE_END
  } mode_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         component_index;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic signed [31:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] pose_value;
    logic               still_active;
    logic               last_component;
  } out_item_t;

  // one entry of the start/end pose store
  typedef struct packed {
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
  } pose_pair_t;

endpackage

### design/eased_timed_pose_blend.sv
// ----------------------------------------------------------------------------
// eased_timed_pose_blend
// timed, eased blend between a stored start pose and end pose
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes load, start and
//   tick transactions; a tick returns one output transaction per pose
//   component on out_valid_o / out_stall_i / out_item_o, index 0 first, with
//   last_component set on the final one. Load and start return nothing.
//   The configuration port writes blend_duration and easing_curve; write it
//   only while the block is idle.
// Operation
//   load finishes in the accepting cycle. start writes one current-pose entry
//   per cycle. A tick mid-blend first runs the one-bit-per-cycle divider, then
//   reads, multiplies and writes back each component through the pose
//   memories. One transaction is worked on at a time; in_stall_o is high
//   until the last result has been handed to the output register.
// Reset
//   duration 0, curve smoothstep, current pose reads as zero, blend inactive.
//   No clearing pass is needed. Start and end poses hold no value until loaded.
// Output stall
//   the output register holds its transaction while out_stall_i is high and
//   the sequencer waits with the next component.
// ----------------------------------------------------------------------------
`include "eased_timed_pose_blend_defines.svh"

module eased_timed_pose_blend
  import etpb_pkg::*;
#(
  parameter int unsigned POSE_COMPONENTS = DEF_POSE_COMPONENTS,
  parameter int unsigned FRACTION_BITS   = DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int unsigned IDX_W = (POSE_COMPONENTS > 1) ? $clog2(POSE_COMPONENTS) : 1;
  localparam int unsigned E_W   = FRACTION_BITS + 1;
  localparam int unsigned SQ_W  = 2 * FRACTION_BITS + 2;
  localparam int unsigned T_W   = FRACTION_BITS + 2;
  localparam int unsigned PR_W  = FRACTION_BITS + 35;
  localparam logic [E_W-1:0] ONE_FX = E_W'(1) << FRACTION_BITS;

  // configuration registers
  logic [31:0] dur_q;
  curve_e      curve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= '0;
      curve_q <= CURVE_SMOOTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DURATION: dur_q   <= cfg_data_i;
        CFG_CURVE:    curve_q <= curve_e'(cfg_data_i[1:0]);
        default:      dur_q   <= dur_q;
      endcase
    end
  end

  // sequencer state
  state_e           state_q, state_d;
  mode_e            mode_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             running_q;
  logic [31:0]      elapsed_q;

  logic             in_acc;
  logic             is_last;
  logic             cur_we;
  logic [31:0]      cur_wdata;
  logic             out_load;
  logic             div_start;
  logic             div_done;
  logic [FRACTION_BITS-1:0] div_quot;

  // memories and read ports
  pose_pair_t               pose_mem_q [POSE_COMPONENTS];
  logic [31:0]              cur_mem_q  [POSE_COMPONENTS];
  logic [POSE_COMPONENTS-1:0] cur_vld_q;
  pose_pair_t               pose_rd_q;
  logic [31:0]              cur_rd_q;
  logic                     cur_rd_vld_q;
  logic                     pose_we;

  // datapath registers
  logic [SQ_W-1:0]      sq_q;
  logic [T_W-1:0]       t_q;
  logic [E_W-1:0]       e_q;
  logic signed [PR_W-1:0] prod_q;
  logic [31:0]          a_q;
  logic [31:0]          hold_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_last    = (idx_q == IDX_W'(POSE_COMPONENTS - 1));

  // elapsed time update of a tick: negative deltas count as zero
  logic [31:0] dt_pos;
  logic [32:0] el_sum;
  logic [31:0] el_new;
  logic        tick_finish;

  assign dt_pos      = in_item_i.delta_time[31] ? 32'd0 : in_item_i.delta_time;
  assign el_sum      = {1'b0, elapsed_q} + {1'b0, dt_pos};
  assign el_new      = (el_sum > {1'b0, dur_q}) ? dur_q : el_sum[31:0];
  assign tick_finish = (el_new == dur_q);

  // emitted value for the current component
  logic signed [PR_W-1:0] prod_sh;
  logic [31:0]            emit_value;

  assign prod_sh    = prod_q >>> FRACTION_BITS;
  assign emit_value = (mode_q == MODE_LERP) ? (a_q + prod_sh[31:0]) : hold_q;

  // next state and control
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cur_we    = 1'b0;
    cur_wdata = emit_value;
    out_load  = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          priority if (in_item_i.action == ACT_START) begin
            state_d = ST_START;
          end else if (in_item_i.action == ACT_TICK) begin
            if (running_q && !tick_finish) begin
              state_d   = ST_DIV;
              div_start = 1'b1;
            end else begin
              state_d = ST_CALC;
            end
          end else begin
            // loads and unused codes finish in the accepting cycle
            state_d = ST_IDLE;
          end
        end
      end
      ST_START: begin
        cur_we    = 1'b1;
        cur_wdata = running_q ? pose_rd_q.start_value : pose_rd_q.end_value;
        if (is_last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EASE1;
        end
      end
      ST_EASE1: state_d = ST_EASE2;
      ST_EASE2: state_d = ST_CALC;
      ST_CALC:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          cur_we   = (mode_q != MODE_HOLD);
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_CALC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      mode_q    <= MODE_HOLD;
      running_q <= 1'b0;
      elapsed_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (in_acc && in_item_i.action == ACT_START) begin
        elapsed_q <= '0;
        running_q <= (dur_q != 32'd0);
      end else if (in_acc && in_item_i.action == ACT_TICK) begin
        if (!running_q) begin
          mode_q <= MODE_HOLD;
        end else begin
          elapsed_q <= el_new;
          if (tick_finish) begin
            mode_q    <= MODE_END;
            running_q <= 1'b0;
          end else begin
            mode_q <= MODE_LERP;
          end
        end
      end
    end
  end

  // progress divider
  etpb_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (el_new),
    .den_i  (dur_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // pose store: written by loads, read at the sequencer's next index
  assign pose_we = in_acc && (in_item_i.action == ACT_LOAD) &&
                   ({1'b0, in_item_i.component_index} < 5'(POSE_COMPONENTS));

  always_ff @(posedge clk_i) begin
    if (pose_we) begin
      pose_mem_q[in_item_i.component_index[IDX_W-1:0]] <=
        '{start_value: in_item_i.start_value, end_value: in_item_i.end_value};
    end
    pose_rd_q <= pose_mem_q[idx_d];
  end

  // current pose store; entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem_q[idx_q] <= cur_wdata;
    end
    cur_rd_q <= cur_mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q    <= '0;
      cur_rd_vld_q <= 1'b0;
    end else begin
      if (cur_we) begin
        cur_vld_q[idx_q] <= 1'b1;
      end
      cur_rd_vld_q <= cur_vld_q[idx_d];
    end
  end

  // easing: square first, then the curve (smoothstep needs a second product)
  logic [E_W-1:0]   ease_base;
  logic [E_W-1:0]   sq_frac;
  logic [SQ_W:0]    smooth_prod;
  logic [E_W-1:0]   ease_next;

  assign ease_base   = (curve_q == CURVE_EASE_OUT) ? (ONE_FX - {1'b0, div_quot})
                                                   : {1'b0, div_quot};
  assign sq_frac     = sq_q[SQ_W-2:FRACTION_BITS];
  assign smooth_prod = (SQ_W + 1)'(sq_frac * t_q);

  always_comb begin
    unique case (curve_q)
      CURVE_LINEAR:   ease_next = {1'b0, div_quot};
      CURVE_EASE_IN:  ease_next = sq_frac;
      CURVE_EASE_OUT: ease_next = ONE_FX - sq_frac;
      CURVE_SMOOTH:   ease_next = smooth_prod[2*FRACTION_BITS:FRACTION_BITS];
      default:        ease_next = {1'b0, div_quot};
    endcase
  end

  // difference of the end and start components
  logic signed [32:0] diff;
  assign diff = {pose_rd_q.end_value[31], pose_rd_q.end_value} -
                {pose_rd_q.start_value[31], pose_rd_q.start_value};

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EASE1) begin
      sq_q <= SQ_W'(ease_base * ease_base);
      t_q  <= T_W'(3 * (2 ** FRACTION_BITS)) - T_W'({div_quot, 1'b0});
    end
    if (state_q == ST_EASE2) begin
      e_q <= ease_next;
    end
    if (state_q == ST_CALC) begin
      prod_q <= diff * $signed({1'b0, e_q});
      a_q    <= pose_rd_q.start_value;
      hold_q <= (mode_q == MODE_END) ? pose_rd_q.end_value
                                     : (cur_rd_vld_q ? cur_rd_q : 32'd0);
    end
    if (out_load) begin
      out_q.out_index      <= 4'(idx_q);
      out_q.pose_value     <= emit_value;
      out_q.still_active   <= running_q;
      out_q.last_component <= is_last;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `ETPB_ASSERT(a_last_index,
    out_valid_o && out_item_o.last_component |->
      out_item_o.out_index == 4'(POSE_COMPONENTS - 1))
  `ETPB_ASSERT(a_div_done_in_div, div_done |-> state_q == ST_DIV)
  `ETPB_ASSERT(a_running_falls_on_accept, $fell(running_q) |-> $past(in_acc))
  `ETPB_ASSERT_NEVER(a_load_while_busy, out_load && state_q != ST_EMIT)

endmodule

### design/etpb_div.sv
// ----------------------------------------------------------------------------
// etpb_div
// restoring divider forming the fractional progress elapsed / duration
// ----------------------------------------------------------------------------
module etpb_div
  import etpb_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              num_i,
  input  logic [31:0]              den_i,
  output logic                     done_o,
  output logic [FRACTION_BITS-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(FRACTION_BITS + 1);

  logic [32:0]              rem_q;
  logic [31:0]              den_q;
  logic [FRACTION_BITS-1:0] quot_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q;
  logic                     done_q;
  logic [32:0]              rem_sh;
  logic                     fits;

  // one quotient bit per cycle; numerator is below the divisor on entry
  assign rem_sh = {rem_q[31:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRACTION_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_q <= {quot_q[FRACTION_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
